/* design/oaid_pkg.sv */
package oaid_pkg;

  localparam int CAPACITY    = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int CMP_W       = 8;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] value;
    logic [5:0]         position;
  } item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] entry;
    logic [5:0]         entry_index;
    logic [6:0]         count;
    logic               last;
  } result_t;

  typedef enum logic [2:0] {
    MODE_APPEND    = 3'd0,
    MODE_INSERT    = 3'd1,
    MODE_DEL_VALUE = 3'd2,
    MODE_DEL_POS   = 3'd3,
    MODE_READ      = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_FULL      = 3'd1,
    STATUS_BAD_POS   = 3'd2,
    STATUS_NOT_FOUND = 3'd3,
    STATUS_EMPTY     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    OP_APPEND,
    OP_INSERT,
    OP_DEL_VALUE,
    OP_DEL_POS,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] value;
    logic [5:0]         position;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT_UP,
    ST_INS_PUT,
    ST_SEARCH,
    ST_SHIFT_DN,
    ST_READ,
    ST_DONE
  } back_state_t;

endpackage

/* design/oaid_front.sv */
module oaid_front (
  input  oaid_pkg::item_t item,
  input  logic            item_valid,
  input  logic            queue_full,
  output logic            item_stall,
  output logic            push,
  output oaid_pkg::cmd_t  cmd
);

  logic known;

  always_comb begin
    known = 1'b1;
    cmd.value = item.value;
    cmd.position = item.position;
    cmd.op = oaid_pkg::OP_APPEND;
    case (item.mode)
      oaid_pkg::MODE_APPEND:    cmd.op = oaid_pkg::OP_APPEND;
      oaid_pkg::MODE_INSERT:    cmd.op = oaid_pkg::OP_INSERT;
      oaid_pkg::MODE_DEL_VALUE: cmd.op = oaid_pkg::OP_DEL_VALUE;
      oaid_pkg::MODE_DEL_POS:   cmd.op = oaid_pkg::OP_DEL_POS;
      oaid_pkg::MODE_READ:      cmd.op = oaid_pkg::OP_READ;
      default:                  known = 1'b0;
    endcase
  end

  // Undefined modes are taken and dropped here; they never reach the queue.
  assign item_stall = queue_full;
  assign push = item_valid && !queue_full && known;

endmodule

/* design/oaid_cmd_queue.sv */
module oaid_cmd_queue #(
  parameter int DEPTH = oaid_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  oaid_pkg::cmd_t push_cmd,
  input  logic           pop,
  output logic           full,
  output logic           head_valid,
  output oaid_pkg::cmd_t head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  oaid_pkg::cmd_t slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [NW-1:0] fill;
  logic          do_push;
  logic          do_pop;

  assign full = (fill == NW'(DEPTH));
  assign head_valid = (fill != '0);
  assign head = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + NW'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - NW'(1);
      end
    end
  end

endmodule

/* design/oaid_back.sv */
module oaid_back #(
  parameter int CAPACITY = oaid_pkg::CAPACITY
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  oaid_pkg::cmd_t    cmd,
  output logic              pop,
  output logic              result_valid,
  output oaid_pkg::result_t result,
  input  logic              result_stall
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int XW = oaid_pkg::CMP_W;

  logic signed [31:0] mem [CAPACITY];

  oaid_pkg::back_state_t state;
  oaid_pkg::back_state_t state_next;
  logic [CW-1:0]         cnt;
  logic [CW-1:0]         cnt_next;
  logic [CW-1:0]         ptr;
  logic [CW-1:0]         ptr_next;
  logic                  rd_vld;
  logic                  rd_vld_next;
  logic [IW-1:0]         rd_idx;
  logic signed [31:0]    rd_data;
  oaid_pkg::status_t     status;
  oaid_pkg::status_t     status_next;
  logic signed [31:0]    cur_value;
  logic [5:0]            cur_position;
  logic                  cur_load;

  logic                  mem_we;
  logic [IW-1:0]         mem_waddr;
  logic signed [31:0]    mem_wdata;
  logic                  mem_re;
  logic [IW-1:0]         mem_raddr;

  logic                  out_load;
  oaid_pkg::result_t     out_data;
  logic                  out_free;

  logic [XW-1:0] cnt_x;
  logic [XW-1:0] pos_x;
  logic [XW-1:0] ptr_x;
  logic [XW-1:0] rd_idx_x;
  logic          is_full;
  logic          cnt_zero;
  logic          ins_bad;
  logic          ins_end;
  logic          del_bad;
  logic          del_tail;
  logic          up_end;
  logic          srch_match;
  logic          srch_tail;
  logic          srch_more;
  logic          dn_more;
  logic          rd_issue;
  logic          rd_emit;
  logic          rd_final;

  assign cnt_x = XW'(cnt);
  assign pos_x = XW'(cmd.position);
  assign ptr_x = XW'(ptr);
  assign rd_idx_x = XW'(rd_idx);

  assign is_full = (cnt_x >= XW'(CAPACITY));
  assign cnt_zero = (cnt == '0);
  assign ins_bad = (cmd.position == 6'd0) || (pos_x > cnt_x + XW'(1));
  assign ins_end = (pos_x == cnt_x + XW'(1));
  assign del_bad = (cmd.position == 6'd0) || (pos_x > cnt_x);
  assign del_tail = (pos_x == cnt_x);
  assign up_end = (ptr_x == XW'(cur_position));
  assign srch_match = rd_vld && (rd_data == cur_value);
  assign srch_tail = (rd_idx_x + XW'(1) == cnt_x);
  assign srch_more = (ptr < cnt);
  assign dn_more = (ptr_x + XW'(2) < cnt_x);
  assign out_free = !result_valid || !result_stall;
  assign rd_issue = (ptr < cnt) && (!rd_vld || out_free);
  assign rd_emit = rd_vld && out_free;
  assign rd_final = (rd_idx_x + XW'(1) == cnt_x);

  always_comb begin
    state_next = state;
    case (state)
      oaid_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            oaid_pkg::OP_APPEND: state_next = oaid_pkg::ST_DONE;
            oaid_pkg::OP_INSERT: begin
              if (!is_full && !ins_bad && !ins_end) begin
                state_next = oaid_pkg::ST_SHIFT_UP;
              end else begin
                state_next = oaid_pkg::ST_DONE;
              end
            end
            oaid_pkg::OP_DEL_VALUE: state_next = oaid_pkg::ST_SEARCH;
            oaid_pkg::OP_DEL_POS: begin
              if (!del_bad && !del_tail) begin
                state_next = oaid_pkg::ST_SHIFT_DN;
              end else begin
                state_next = oaid_pkg::ST_DONE;
              end
            end
            oaid_pkg::OP_READ: begin
              state_next = cnt_zero ? oaid_pkg::ST_DONE : oaid_pkg::ST_READ;
            end
            default: state_next = oaid_pkg::ST_IDLE;
          endcase
        end
      end
      oaid_pkg::ST_SHIFT_UP: begin
        if (up_end) begin
          state_next = oaid_pkg::ST_INS_PUT;
        end
      end
      oaid_pkg::ST_INS_PUT: state_next = oaid_pkg::ST_DONE;
      oaid_pkg::ST_SEARCH: begin
        if (srch_match) begin
          state_next = srch_tail ? oaid_pkg::ST_DONE : oaid_pkg::ST_SHIFT_DN;
        end else if (!srch_more) begin
          state_next = oaid_pkg::ST_DONE;
        end
      end
      oaid_pkg::ST_SHIFT_DN: begin
        if (!dn_more) begin
          state_next = oaid_pkg::ST_DONE;
        end
      end
      oaid_pkg::ST_READ: begin
        if (rd_emit && rd_final) begin
          state_next = oaid_pkg::ST_IDLE;
        end
      end
      oaid_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = oaid_pkg::ST_IDLE;
        end
      end
      default: state_next = oaid_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pop = 1'b0;
    cur_load = 1'b0;
    cnt_next = cnt;
    ptr_next = ptr;
    rd_vld_next = rd_vld;
    status_next = status;
    mem_we = 1'b0;
    mem_waddr = '0;
    mem_wdata = cmd.value;
    mem_re = 1'b0;
    mem_raddr = '0;
    out_load = 1'b0;
    out_data.status = status;
    out_data.entry = '0;
    out_data.entry_index = '0;
    out_data.count = 7'(cnt);
    out_data.last = 1'b1;
    case (state)
      oaid_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          pop = 1'b1;
          cur_load = 1'b1;
          case (cmd.op)
            oaid_pkg::OP_APPEND: begin
              if (is_full) begin
                status_next = oaid_pkg::STATUS_FULL;
              end else begin
                status_next = oaid_pkg::STATUS_OK;
                mem_we = 1'b1;
                mem_waddr = IW'(cnt);
                cnt_next = cnt + CW'(1);
              end
            end
            oaid_pkg::OP_INSERT: begin
              if (is_full) begin
                status_next = oaid_pkg::STATUS_FULL;
              end else if (ins_bad) begin
                status_next = oaid_pkg::STATUS_BAD_POS;
              end else if (ins_end) begin
                status_next = oaid_pkg::STATUS_OK;
                mem_we = 1'b1;
                mem_waddr = IW'(cnt);
                cnt_next = cnt + CW'(1);
              end else begin
                status_next = oaid_pkg::STATUS_OK;
                mem_re = 1'b1;
                mem_raddr = IW'(cnt - CW'(1));
                ptr_next = cnt;
              end
            end
            oaid_pkg::OP_DEL_VALUE: begin
              status_next = oaid_pkg::STATUS_NOT_FOUND;
              ptr_next = '0;
              rd_vld_next = 1'b0;
            end
            oaid_pkg::OP_DEL_POS: begin
              if (del_bad) begin
                status_next = oaid_pkg::STATUS_BAD_POS;
              end else begin
                status_next = oaid_pkg::STATUS_OK;
                if (del_tail) begin
                  cnt_next = cnt - CW'(1);
                end else begin
                  mem_re = 1'b1;
                  mem_raddr = IW'(cmd.position);
                  ptr_next = CW'(cmd.position - 6'd1);
                end
              end
            end
            oaid_pkg::OP_READ: begin
              if (cnt_zero) begin
                status_next = oaid_pkg::STATUS_EMPTY;
              end else begin
                ptr_next = '0;
                rd_vld_next = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      oaid_pkg::ST_SHIFT_UP: begin
        mem_we = 1'b1;
        mem_waddr = IW'(ptr);
        mem_wdata = rd_data;
        if (!up_end) begin
          mem_re = 1'b1;
          mem_raddr = IW'(ptr - CW'(2));
          ptr_next = ptr - CW'(1);
        end
      end
      oaid_pkg::ST_INS_PUT: begin
        mem_we = 1'b1;
        mem_waddr = IW'(cur_position - 6'd1);
        mem_wdata = cur_value;
        cnt_next = cnt + CW'(1);
      end
      oaid_pkg::ST_SEARCH: begin
        if (srch_match) begin
          status_next = oaid_pkg::STATUS_OK;
          rd_vld_next = 1'b0;
          if (srch_tail) begin
            cnt_next = cnt - CW'(1);
          end else begin
            mem_re = 1'b1;
            mem_raddr = rd_idx + IW'(1);
            ptr_next = CW'(rd_idx);
          end
        end else if (srch_more) begin
          mem_re = 1'b1;
          mem_raddr = IW'(ptr);
          ptr_next = ptr + CW'(1);
          rd_vld_next = 1'b1;
        end
      end
      oaid_pkg::ST_SHIFT_DN: begin
        mem_we = 1'b1;
        mem_waddr = IW'(ptr);
        mem_wdata = rd_data;
        if (dn_more) begin
          mem_re = 1'b1;
          mem_raddr = IW'(ptr + CW'(2));
          ptr_next = ptr + CW'(1);
        end else begin
          cnt_next = cnt - CW'(1);
        end
      end
      oaid_pkg::ST_READ: begin
        if (rd_issue) begin
          mem_re = 1'b1;
          mem_raddr = IW'(ptr);
          ptr_next = ptr + CW'(1);
          rd_vld_next = 1'b1;
        end else if (rd_emit) begin
          rd_vld_next = 1'b0;
        end
        if (rd_emit) begin
          out_load = 1'b1;
          out_data.status = oaid_pkg::STATUS_OK;
          out_data.entry = rd_data;
          out_data.entry_index = 6'(rd_idx);
          out_data.last = rd_final;
        end
      end
      oaid_pkg::ST_DONE: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
      rd_idx <= mem_raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (cur_load) begin
      cur_value <= cmd.value;
      cur_position <= cmd.position;
    end
    status <= status_next;
    ptr <= ptr_next;
    if (out_load) begin
      result <= out_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= oaid_pkg::ST_IDLE;
      cnt <= '0;
      rd_vld <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      rd_vld <= rd_vld_next;
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

/* design/ordered_array_insert_delete_unit.sv */
// Ordered list of up to CAPACITY signed 32-bit entries with a count.
// Each transaction on the item channel carries a mode, a value and a
// 1-based position; the result channel returns one status transaction for
// append, insert, both deletes and read-all of an empty list, or one
// transaction per entry for read-all, the final one of each item marked by
// last. Undefined modes are taken and give nothing.
// Items pass through a two-deep command queue, so the item channel keeps
// accepting while the back end works or waits on a stalled result, until
// the queue is full. The back end handles one item at a time around a
// single-port-write, single-port-read entry memory: append, and insert at
// the end, write directly; insert elsewhere shifts the entries up one at
// a time and then places the value; delete at a position shifts the later
// entries down; delete by value searches entry by entry and then shifts;
// read-all emits one entry per cycle while result_stall is low, behind a
// registered memory read.
// The result register holds its transaction while result_stall is high, and
// the back end waits to load its next result until it drains.
// Reset empties the list; entry storage is not cleared and is never read
// before it is written.
module ordered_array_insert_delete_unit #(
  parameter int CAPACITY    = oaid_pkg::CAPACITY,
  parameter int QUEUE_DEPTH = oaid_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  oaid_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output oaid_pkg::result_t result
);

  logic           push;
  logic           queue_full;
  oaid_pkg::cmd_t push_cmd;
  logic           head_valid;
  oaid_pkg::cmd_t head;
  logic           pop;

  oaid_front u_front (
    .item       (item),
    .item_valid (item_valid),
    .queue_full (queue_full),
    .item_stall (item_stall),
    .push       (push),
    .cmd        (push_cmd)
  );

  oaid_cmd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .full       (queue_full),
    .head_valid (head_valid),
    .head       (head)
  );

  oaid_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (head_valid),
    .cmd          (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result       (result),
    .result_stall (result_stall)
  );

endmodule

/* bench/oaid_list_checker.sv */
module oaid_list_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_stall,
  input  oaid_pkg::item_t   item,
  input  logic              result_valid,
  input  logic              result_stall,
  input  oaid_pkg::result_t result,
  output int                mismatches,
  output int                outstanding,
  output int                held,
  output int                items_taken,
  output int                results_checked,
  output int                full_rejects
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [31:0] list_mem [oaid_pkg::CAPACITY];
  int                 list_len;
  oaid_pkg::result_t  pending_results [$];

  function automatic oaid_pkg::result_t status_result(oaid_pkg::status_t st);
    oaid_pkg::result_t r;
    r = '0;
    r.status = st;
    r.count = 7'(list_len);
    r.last = 1'b1;
    return r;
  endfunction

  function automatic void drop_entry(int idx);
    for (int i = idx; i + 1 < list_len; i++) list_mem[i] = list_mem[i + 1];
    list_len--;
  endfunction

  task automatic apply_list_op(oaid_pkg::item_t it);
    int                pos;
    int                hit;
    oaid_pkg::result_t r;
    pos = int'(it.position);
    case (it.mode)
      oaid_pkg::MODE_APPEND: begin
        if (list_len >= oaid_pkg::CAPACITY) begin
          full_rejects++;
          pending_results.push_back(status_result(oaid_pkg::STATUS_FULL));
        end else begin
          list_mem[list_len] = it.value;
          list_len++;
          pending_results.push_back(status_result(oaid_pkg::STATUS_OK));
        end
      end
      oaid_pkg::MODE_INSERT: begin
        if (list_len >= oaid_pkg::CAPACITY) begin
          full_rejects++;
          pending_results.push_back(status_result(oaid_pkg::STATUS_FULL));
        end else if (pos < 1 || pos > list_len + 1) begin
          pending_results.push_back(status_result(oaid_pkg::STATUS_BAD_POS));
        end else begin
          for (int i = list_len; i >= pos; i--) list_mem[i] = list_mem[i - 1];
          list_mem[pos - 1] = it.value;
          list_len++;
          pending_results.push_back(status_result(oaid_pkg::STATUS_OK));
        end
      end
      oaid_pkg::MODE_DEL_VALUE: begin
        hit = -1;
        for (int i = 0; i < list_len; i++) begin
          if (hit < 0 && list_mem[i] == it.value) hit = i;
        end
        if (hit < 0) begin
          pending_results.push_back(status_result(oaid_pkg::STATUS_NOT_FOUND));
        end else begin
          drop_entry(hit);
          pending_results.push_back(status_result(oaid_pkg::STATUS_OK));
        end
      end
      oaid_pkg::MODE_DEL_POS: begin
        if (pos < 1 || pos > list_len) begin
          pending_results.push_back(status_result(oaid_pkg::STATUS_BAD_POS));
        end else begin
          drop_entry(pos - 1);
          pending_results.push_back(status_result(oaid_pkg::STATUS_OK));
        end
      end
      oaid_pkg::MODE_READ: begin
        if (list_len == 0) begin
          pending_results.push_back(status_result(oaid_pkg::STATUS_EMPTY));
        end else begin
          for (int i = 0; i < list_len; i++) begin
            r = '0;
            r.status = oaid_pkg::STATUS_OK;
            r.entry = list_mem[i];
            r.entry_index = 6'(i);
            r.count = 7'(list_len);
            r.last = (i == list_len - 1);
            pending_results.push_back(r);
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic log_mismatch(string what, oaid_pkg::result_t want, oaid_pkg::result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("ERROR at %0t: %s", $realtime, what);
      $display("  expected status=%0d entry=%0d index=%0d count=%0d last=%0b",
               want.status, want.entry, want.entry_index, want.count, want.last);
      $display("  actual   status=%0d entry=%0d index=%0d count=%0d last=%0b",
               got.status, got.entry, got.entry_index, got.count, got.last);
    end
  endtask

  always @(posedge clk) begin
    oaid_pkg::result_t want;
    if (rst) begin
      list_len = 0;
      pending_results.delete();
    end else begin
      if (result_valid && !result_stall) begin
        results_checked++;
        if (pending_results.size() == 0) begin
          log_mismatch("result transaction with none expected", '0, result);
        end else begin
          want = pending_results.pop_front();
          if (result.status !== want.status || result.entry !== want.entry ||
              result.entry_index !== want.entry_index ||
              result.count !== want.count || result.last !== want.last) begin
            log_mismatch("result transaction differs", want, result);
          end
        end
      end
      if (item_valid && !item_stall) begin
        items_taken++;
        apply_list_op(item);
      end
    end
    outstanding = pending_results.size();
    held = list_len;
  end

endmodule

/* bench/tb_ordered_array_insert_delete_unit.sv */
module tb_ordered_array_insert_delete_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS  = 190;
  localparam int PHASE_ITEMS   = 60;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = oaid_pkg::CAPACITY + 8;

  logic              clk;
  logic              rst;
  logic              item_valid;
  logic              item_stall;
  oaid_pkg::item_t   item;
  logic              result_valid;
  logic              result_stall;
  oaid_pkg::result_t result;

  int mismatches;
  int outstanding;
  int held;
  int items_taken;
  int results_checked;
  int full_rejects;

  logic calm;
  logic hold_req;
  int   ignored_sent;

  logic signed [31:0] value_pool [8] = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0, -32'sd1,
                                         32'sd1, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sd7};

  ordered_array_insert_delete_unit dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  oaid_list_checker list_monitor (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item_stall      (item_stall),
    .item            (item),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .result          (result),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .held            (held),
    .items_taken     (items_taken),
    .results_checked (results_checked),
    .full_rejects    (full_rejects)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic oaid_pkg::item_t make_item(logic [2:0] m, logic signed [31:0] v, int p);
    oaid_pkg::item_t it;
    it.mode = m;
    it.value = v;
    it.position = 6'(p);
    return it;
  endfunction

  function automatic logic [2:0] pick_mode(bit growing);
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return oaid_pkg::MODE_READ + 3'($urandom_range(1, 3));
    if (r < 14) return oaid_pkg::MODE_READ;
    if (growing) begin
      if (r < 57) return oaid_pkg::MODE_APPEND;
      if (r < 86) return oaid_pkg::MODE_INSERT;
      if (r < 93) return oaid_pkg::MODE_DEL_VALUE;
      return oaid_pkg::MODE_DEL_POS;
    end
    if (r < 21) return oaid_pkg::MODE_APPEND;
    if (r < 28) return oaid_pkg::MODE_INSERT;
    if (r < 64) return oaid_pkg::MODE_DEL_VALUE;
    return oaid_pkg::MODE_DEL_POS;
  endfunction

  function automatic logic signed [31:0] pick_value();
    if ($urandom_range(0, 1) == 0) return value_pool[$urandom_range(0, 7)];
    return 32'($urandom);
  endfunction

  function automatic int pick_position(logic [2:0] m);
    int hi;
    hi = (m == oaid_pkg::MODE_INSERT) ? held + 1 : held;
    if ($urandom_range(0, 9) == 0 || hi < 1) return $urandom_range(0, 63);
    return $urandom_range(1, hi);
  endfunction

  // Called at a falling edge; returns at a falling edge with no pending
  // change to the item channel in that time step.
  task automatic offer(oaid_pkg::item_t it);
    int gap;
    item <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin : result_side
    int stall_len;
    result_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        result_stall <= 1'b0;
      end else begin
        stall_len = pick_gap();
        if (stall_len > 0) begin
          result_stall <= 1'b1;
          repeat (stall_len) @(negedge clk);
          result_stall <= 1'b0;
        end
      end
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  end

  initial begin : item_side
    logic [2:0] m;
    int         done_items;
    bit         hold_started;
    bit         paused;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    calm = 1'b0;
    hold_req = 1'b0;
    ignored_sent = 0;
    hold_started = 0;
    paused = 0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    offer(make_item(oaid_pkg::MODE_READ, 32'sd0, 0));
    offer(make_item(oaid_pkg::MODE_DEL_VALUE, 32'sd0, 0));
    offer(make_item(oaid_pkg::MODE_DEL_POS, 32'sd0, 1));
    offer(make_item(oaid_pkg::MODE_INSERT, 32'sd9, 0));
    offer(make_item(oaid_pkg::MODE_INSERT, 32'sd9, 2));
    offer(make_item(oaid_pkg::MODE_INSERT, 32'sh7FFF_FFFF, 1));
    offer(make_item(oaid_pkg::MODE_APPEND, 32'sh8000_0000, 0));
    offer(make_item(oaid_pkg::MODE_APPEND, 32'sd0, 0));
    offer(make_item(oaid_pkg::MODE_APPEND, -32'sd1, 63));
    offer(make_item(oaid_pkg::MODE_APPEND, 32'sd0, 0));
    offer(make_item(oaid_pkg::MODE_INSERT, 32'sd1, 1));
    offer(make_item(oaid_pkg::MODE_INSERT, 32'sh5555_5555, 7));
    offer(make_item(oaid_pkg::MODE_INSERT, 32'shAAAA_AAAA, 3));
    offer(make_item(oaid_pkg::MODE_INSERT, 32'sd3, 63));
    offer(make_item(oaid_pkg::MODE_READ, 32'sd0, 0));
    offer(make_item(oaid_pkg::MODE_DEL_VALUE, 32'sd0, 0));
    offer(make_item(oaid_pkg::MODE_DEL_VALUE, 32'sd12345, 0));
    offer(make_item(oaid_pkg::MODE_DEL_POS, 32'sd0, 63));
    offer(make_item(oaid_pkg::MODE_DEL_POS, 32'sd0, 0));
    offer(make_item(oaid_pkg::MODE_DEL_POS, 32'sd0, 1));
    offer(make_item(oaid_pkg::MODE_DEL_POS, 32'sd0, 6));
    offer(make_item(oaid_pkg::MODE_READ + 3'd1, 32'sh7FFF_FFFF, 63));
    offer(make_item(oaid_pkg::MODE_READ + 3'd3, -32'sd1, 63));
    offer(make_item(oaid_pkg::MODE_READ, 32'sd0, 0));
    ignored_sent = 2;
    wait_drained();

    done_items = 0;
    while (done_items < RANDOM_ITEMS) begin
      calm = (done_items >= 30 && done_items < 50);
      if (done_items == 100 && !hold_started) begin
        hold_started = 1;
        hold_req = 1'b1;
      end
      if (done_items == 150 && !paused) begin
        paused = 1;
        wait_drained();
      end
      m = pick_mode(((done_items / PHASE_ITEMS) % 2) == 0);
      offer(make_item(m, pick_value(), pick_position(m)));
      if (m <= oaid_pkg::MODE_READ) done_items++;
      else ignored_sent++;
    end

    item_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (2 * oaid_pkg::CAPACITY + 10) @(negedge clk);
    $display("Run covered %0d item transactions (%0d with undefined modes) and %0d results,",
             items_taken, ignored_sent, results_checked);
    $display("including %0d rejections on a full list and a long result hold-off.",
             full_rejects);
    if (mismatches == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
